// ===== rtl/core/prefix_expression_stack_evaluator_core_assert.svh =====
// Assertion macros for the prefix expression stack evaluator.
`ifndef PREFIX_EXPRESSION_STACK_EVALUATOR_CORE_ASSERT_SVH
`define PREFIX_EXPRESSION_STACK_EVALUATOR_CORE_ASSERT_SVH
`ifndef SYNTH
`define PESE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PESE_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PESE_ASSERT(label, clk, rst, prop, msg)
`define PESE_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== rtl/core/pese_pkg.sv =====
// ----------------------------------------------------------------------------
// pese_pkg
// Types, codes and constants of the prefix expression stack evaluator.
// ----------------------------------------------------------------------------
package pese_pkg;
   localparam int STACK_DEPTH = 16;
   localparam int PTR_W = $clog2(STACK_DEPTH);
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int DIV_CNT_W = 6;

   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;
   localparam logic [7:0] CH_ADD = 8'h2b;
   localparam logic [7:0] CH_SUB = 8'h2d;
   localparam logic [7:0] CH_MUL = 8'h78;
   localparam logic [7:0] CH_DIV = 8'h2f;

   typedef enum logic [1:0] {
      ST_OK = 2'd0,
      ST_UNDERFLOW = 2'd1,
      ST_DIVZERO = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      OP_NONE, OP_DIGIT, OP_ADD, OP_SUB, OP_MUL, OP_DIV
   } op_type;

   typedef enum logic [2:0] {
      BK_IDLE, BK_READ, BK_EXEC, BK_MUL, BK_DIV, BK_FIX, BK_OUT
   } back_state_type;

   typedef struct packed {
      logic [7:0] token_char;
      logic clear_first;
   } req_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      op_type op;
      logic clear_first;
      logic [3:0] digit;
   } cmd_type;
endpackage

// ===== rtl/core/pese_front.sv =====
// ----------------------------------------------------------------------------
// pese_front
// Accepts tokens, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module pese_front (
   input logic clock,
   input logic reset,
   input logic req_push,
   output logic req_full,
   input pese_pkg::req_type req_data,
   output logic cmd_valid,
   input logic cmd_take,
   output pese_pkg::cmd_type cmd_data
);
   import pese_pkg::*;

   cmd_type q_ff [2];
   logic rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0] cnt_ff, cnt_in;
   cmd_type cls;
   logic push_ok, take_ok;

   always_comb begin
      cls.clear_first = req_data.clear_first;
      cls.digit = 4'(req_data.token_char - CH_ZERO);
      if (req_data.token_char >= CH_ZERO && req_data.token_char <= CH_NINE) begin
         cls.op = OP_DIGIT;
      end else begin
         case (req_data.token_char)
            CH_ADD: cls.op = OP_ADD;
            CH_SUB: cls.op = OP_SUB;
            CH_MUL: cls.op = OP_MUL;
            CH_DIV: cls.op = OP_DIV;
            default: cls.op = OP_NONE;
         endcase
      end
   end

   assign req_full = cnt_ff == 2'd2;
   assign cmd_valid = cnt_ff != 2'd0;
   assign cmd_data = q_ff[rd_ff];
   assign push_ok = req_push && !req_full;
   assign take_ok = cmd_take && cmd_valid;

   always_comb begin
      rd_in = rd_ff ^ take_ok;
      wr_in = wr_ff ^ push_ok;
      cnt_in = cnt_ff + 2'(push_ok) - 2'(take_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         rd_ff <= rd_in;
         wr_ff <= wr_in;
         cnt_ff <= cnt_in;
      end
      if (push_ok) begin
         q_ff[wr_ff] <= cls;
      end
   end
endmodule

// ===== rtl/core/pese_back.sv =====
// ----------------------------------------------------------------------------
// pese_back
// Executes classified tokens on the operand stack and holds one result.
// ----------------------------------------------------------------------------
module pese_back (
   input logic clock,
   input logic reset,
   input logic cmd_valid,
   output logic cmd_take,
   input pese_pkg::cmd_type cmd_data,
   output logic rsp_empty,
   input logic rsp_pop,
   output pese_pkg::rsp_type rsp_data
);
   import pese_pkg::*;
   `include "prefix_expression_stack_evaluator_core_assert.svh"

   logic [31:0] stack_mem [STACK_DEPTH];
   back_state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   cmd_type cmd_ff, cmd_in;
   logic [31:0] left_ff, right_ff;
   logic [31:0] acc_ff, acc_in, rem_ff, rem_in, dvs_ff, dvs_in;
   logic neg_ff, neg_in;
   logic [DIV_CNT_W-1:0] step_ff, step_in;
   rsp_type res_ff, res_in;
   rsp_type out_ff, out_in;
   logic full_ff, full_in;
   logic wr_en;
   logic [PTR_W-1:0] wr_addr;
   logic [31:0] wr_data;
   logic rd_en;
   logic [PTR_W-1:0] rd_top_addr, rd_next_addr;
   logic [32:0] trial;
   logic [31:0] prod;
   logic div_last;
   logic rsp_wait;

   assign rsp_empty = !full_ff;
   assign rsp_data = out_ff;
   assign trial = {rem_ff, acc_ff[31]} - {1'b0, dvs_ff};
   assign prod = left_ff * right_ff;
   assign div_last = state_ff == BK_DIV && step_ff == DIV_CNT_W'(31);
   assign rsp_wait = !rsp_empty && !rsp_pop;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      cmd_in = cmd_ff;
      acc_in = acc_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      neg_in = neg_ff;
      step_in = step_ff;
      res_in = res_ff;
      out_in = out_ff;
      full_in = full_ff && !rsp_pop;
      cmd_take = 1'b0;
      wr_en = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      rd_en = 1'b0;
      rd_top_addr = '0;
      rd_next_addr = '0;
      case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               cmd_take = 1'b1;
               cmd_in = cmd_data;
               if (cmd_data.clear_first) begin
                  count_in = '0;
               end
               state_in = BK_READ;
            end
         end
         BK_READ: begin
            state_in = BK_IDLE;
            case (cmd_ff.op)
               OP_DIGIT: begin
                  if (count_ff >= CNT_W'(STACK_DEPTH)) begin
                     res_in = '{value: '0, status: ST_OVERFLOW};
                     state_in = BK_OUT;
                  end else begin
                     wr_en = 1'b1;
                     wr_addr = count_ff[PTR_W-1:0];
                     wr_data = 32'(cmd_ff.digit);
                     count_in = count_ff + 1'b1;
                  end
               end
               OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                  if (count_ff < CNT_W'(2)) begin
                     res_in = '{value: '0, status: ST_UNDERFLOW};
                     state_in = BK_OUT;
                  end else begin
                     rd_en = 1'b1;
                     rd_top_addr = PTR_W'(count_ff - 1'b1);
                     rd_next_addr = PTR_W'(count_ff - 2'd2);
                     state_in = BK_EXEC;
                  end
               end
               default: state_in = BK_IDLE;
            endcase
         end
         BK_EXEC: begin
            state_in = BK_OUT;
            res_in.status = ST_OK;
            case (cmd_ff.op)
               OP_ADD: res_in.value = left_ff + right_ff;
               OP_SUB: res_in.value = left_ff - right_ff;
               OP_MUL: state_in = BK_MUL;
               default: begin
                  if (right_ff == '0) begin
                     res_in = '{value: '0, status: ST_DIVZERO};
                  end else begin
                     acc_in = left_ff[31] ? -left_ff : left_ff;
                     dvs_in = right_ff[31] ? -right_ff : right_ff;
                     neg_in = left_ff[31] ^ right_ff[31];
                     rem_in = '0;
                     step_in = '0;
                     state_in = BK_DIV;
                  end
               end
            endcase
         end
         BK_MUL: begin
            res_in.value = prod;
            state_in = BK_OUT;
         end
         BK_DIV: begin
            if (!trial[32]) begin
               rem_in = trial[31:0];
               acc_in = {acc_ff[30:0], 1'b1};
            end else begin
               rem_in = {rem_ff[30:0], acc_ff[31]};
               acc_in = {acc_ff[30:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (div_last) begin
               state_in = BK_FIX;
            end
         end
         BK_FIX: begin
            res_in.value = neg_ff ? -acc_ff : acc_ff;
            state_in = BK_OUT;
         end
         BK_OUT: begin
            if (!full_ff || rsp_pop) begin
               full_in = 1'b1;
               out_in = res_ff;
               state_in = BK_IDLE;
               if (res_ff.status == ST_OK) begin
                  wr_en = 1'b1;
                  wr_addr = PTR_W'(count_ff - 2'd2);
                  wr_data = res_ff.value;
                  count_in = count_ff - 1'b1;
               end
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         count_ff <= '0;
         full_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         full_ff <= full_in;
      end
      cmd_ff <= cmd_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
      step_ff <= step_in;
      res_ff <= res_in;
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         left_ff <= stack_mem[rd_top_addr];
         right_ff <= stack_mem[rd_next_addr];
      end
   end

   `PESE_ASSERT(a_count_range, clock, reset, count_ff <= CNT_W'(STACK_DEPTH), "count too large")
   `PESE_ASSERT(a_take_idle, clock, reset, cmd_take |-> state_ff == BK_IDLE, "take while busy")
   `PESE_ASSERT(a_div_len, clock, reset, div_last |=> state_ff == BK_FIX, "divider length")
   `PESE_ASSERT(a_rsp_hold, clock, reset, rsp_wait |=> $stable(rsp_data), "result changed")
endmodule

// ===== rtl/core/prefix_expression_stack_evaluator_core.sv =====
// ----------------------------------------------------------------------------
// prefix_expression_stack_evaluator_core
// Prefix expression evaluator with an operand stack and a result queue.
// ----------------------------------------------------------------------------
// Tokens enter on the req_ queue port: an item is taken when req_push is
// high and req_full is low. A front stage classifies each token into a
// two-entry queue, and a back stage executes it on a 16-entry operand
// stack. Results leave on the rsp_ port: the oldest result is shown while
// rsp_empty is low and is taken when rsp_pop is high.
// A digit or an ignored token passes the idle and read states of the back
// stage. Add and subtract pass read, execute and output, and multiply adds
// a multiply state; the back stage takes no new item before the last one
// is through. Division runs a one-bit-per-cycle restoring divider and a
// sign fix state, which sets the worst-case rate. Underflow and overflow
// results go from read to output, divide by zero from execute to output.
// Reset empties the stack and both queues.
// When the receiver stalls, one result waits in the output register and
// the back stage holds the next result until that register frees; the
// front queue then fills and raises req_full.
module prefix_expression_stack_evaluator_core (
   input logic clock,
   input logic reset,
   input logic req_push,
   output logic req_full,
   input pese_pkg::req_type req_data,
   output logic rsp_empty,
   input logic rsp_pop,
   output pese_pkg::rsp_type rsp_data
);
   import pese_pkg::*;

   logic cmd_valid, cmd_take;
   cmd_type cmd_data;

   pese_front u_front (
      .clock, .reset, .req_push, .req_full, .req_data,
      .cmd_valid, .cmd_take, .cmd_data
   );

   pese_back u_back (
      .clock, .reset, .cmd_valid, .cmd_take, .cmd_data,
      .rsp_empty, .rsp_pop, .rsp_data
   );
endmodule

// ===== tb/tb_prefix_expression_stack_evaluator_core.sv =====
// ----------------------------------------------------------------------------
// tb_prefix_expression_stack_evaluator_core
// Self-checking testbench for the prefix expression stack evaluator.
// ----------------------------------------------------------------------------
// A directed table covers digits, every operator, stack overflow, underflow,
// divide by zero, ignored tokens and clears. A directed sequence divides the
// most negative value by minus one. Noisy random prefix expressions follow.
// Each accepted item is run through a predictor of the operand stack, and
// the expected results are compared with the results popped from the block.
// ----------------------------------------------------------------------------
module tb_prefix_expression_stack_evaluator_core;
   timeunit 1ns;
   timeprecision 1ps;

   import pese_pkg::*;

   localparam int MAX_MISMATCH_PRINTS = 10;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct {
      req_type req;
      logic check_typed;
      rsp_type rsp;
   } table_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   req_type req_data = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   rsp_type rsp_data;

   logic [31:0] eval_stack [STACK_DEPTH];
   int eval_count = 0;
   rsp_type expected_results [$];
   table_row_type stim_table [$];
   int mismatch_count = 0;
   int send_idle_pct = 0;
   int pop_stall_pct = 0;
   int hold_off_cycles = 0;
   longint cycle_count = 0;

   prefix_expression_stack_evaluator_core i_dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_data(req_data),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_data(rsp_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_prefix_expression_stack_evaluator_core: FAIL");
         $finish;
      end
   end

   function automatic logic [31:0] div_toward_zero(logic [31:0] a, logic [31:0] b);
      logic [31:0] ua;
      logic [31:0] ub;
      logic [31:0] q;
      ua = a[31] ? -a : a;
      ub = b[31] ? -b : b;
      q = ua / ub;
      return (a[31] != b[31]) ? -q : q;
   endfunction

   function automatic rsp_type make_rsp(logic [31:0] v, status_type s);
      rsp_type r;
      r.value = v;
      r.status = s;
      return r;
   endfunction

   task automatic evaluate_token(input req_type req);
      logic [31:0] lhs;
      logic [31:0] rhs;
      logic [31:0] res;
      if (req.clear_first) eval_count = 0;
      if (req.token_char >= CH_ZERO && req.token_char <= CH_NINE) begin
         if (eval_count >= STACK_DEPTH) begin
            expected_results.push_back(make_rsp('0, ST_OVERFLOW));
         end else begin
            eval_stack[eval_count] = {28'd0, 4'(req.token_char - CH_ZERO)};
            eval_count++;
         end
         return;
      end
      if (!(req.token_char inside {CH_ADD, CH_SUB, CH_MUL, CH_DIV})) return;
      if (eval_count < 2) begin
         expected_results.push_back(make_rsp('0, ST_UNDERFLOW));
         return;
      end
      lhs = eval_stack[eval_count - 1];
      rhs = eval_stack[eval_count - 2];
      case (req.token_char)
         CH_ADD: res = lhs + rhs;
         CH_SUB: res = lhs - rhs;
         CH_MUL: res = lhs * rhs;
         default: begin
            if (rhs == 0) begin
               expected_results.push_back(make_rsp('0, ST_DIVZERO));
               return;
            end
            res = div_toward_zero(lhs, rhs);
         end
      endcase
      eval_count--;
      eval_stack[eval_count - 1] = res;
      expected_results.push_back(make_rsp(res, ST_OK));
   endtask

   task automatic send_item(input req_type req);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_data <= req;
      @(posedge clock);
      while (req_full) @(posedge clock);
      evaluate_token(req);
      @(negedge clock);
   endtask

   task automatic check_typed_row(input table_row_type row);
      rsp_type pred;
      pred = expected_results[$];
      if (pred != row.rsp) begin
         mismatch_count++;
         if (mismatch_count <= MAX_MISMATCH_PRINTS)
            $display("table row mismatch: typed %h predicted %h", row.rsp, pred);
      end
   endtask

   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_MISMATCH_PRINTS)
               $display("unexpected result: value %h status %0d",
                  rsp_data.value, rsp_data.status);
         end else begin
            exp_rsp = expected_results.pop_front();
            if (rsp_data.value !== exp_rsp.value || rsp_data.status !== exp_rsp.status) begin
               mismatch_count++;
               if (mismatch_count <= MAX_MISMATCH_PRINTS)
                  $display("result mismatch: expected value %h status %0d, got value %h status %0d",
                     exp_rsp.value, exp_rsp.status, rsp_data.value, rsp_data.status);
            end
         end
      end
   end

   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
      end
   end

   function automatic req_type tok(logic [7:0] c, logic clr);
      req_type r;
      r.token_char = c;
      r.clear_first = clr;
      return r;
   endfunction

   task automatic add_row(logic [7:0] c, logic clr, logic typed, logic [31:0] v,
         status_type s);
      table_row_type row;
      row.req = tok(c, clr);
      row.check_typed = typed;
      row.rsp = make_rsp(v, s);
      stim_table.push_back(row);
   endtask

   function automatic logic [7:0] random_digit();
      return CH_ZERO + 8'($urandom_range(9));
   endfunction

   function automatic logic [7:0] random_operator();
      case ($urandom_range(3))
         0: return CH_ADD;
         1: return CH_SUB;
         2: return CH_MUL;
         default: return CH_DIV;
      endcase
   endfunction

   task automatic send_random_expression();
      int n_ops;
      int depth;
      n_ops = $urandom_range(1, 6);
      send_item(tok(random_digit(), 1'b1));
      depth = 1;
      for (int i = 0; i < 2 * n_ops; i++) begin
         if (depth < 2 || (depth < STACK_DEPTH && $urandom_range(1))) begin
            send_item(tok(random_digit(), 1'b0));
            depth++;
         end else begin
            send_item(tok(random_operator(), 1'b0));
            depth--;
         end
         if ($urandom_range(19) == 0) send_item(tok(8'($urandom), 1'($urandom)));
      end
      while (depth >= 2) begin
         send_item(tok(random_operator(), 1'b0));
         depth--;
      end
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   initial begin
      int sent;
      add_row(CH_ADD, 1'b0, 1'b1, 32'd0, ST_UNDERFLOW);
      add_row(CH_NINE, 1'b0, 1'b0, 32'd0, ST_OK);
      add_row(CH_DIV, 1'b0, 1'b1, 32'd0, ST_UNDERFLOW);
      add_row(CH_ZERO, 1'b0, 1'b0, 32'd0, ST_OK);
      add_row(CH_NINE, 1'b0, 1'b0, 32'd0, ST_OK);
      add_row(CH_DIV, 1'b0, 1'b1, 32'd0, ST_DIVZERO);
      add_row(CH_ADD, 1'b0, 1'b1, 32'd9, ST_OK);
      add_row(CH_ZERO + 8'd3, 1'b0, 1'b0, 32'd0, ST_OK);
      add_row(CH_SUB, 1'b0, 1'b1, 32'hFFFFFFFA, ST_OK);
      add_row(CH_ZERO + 8'd2, 1'b0, 1'b0, 32'd0, ST_OK);
      add_row(CH_MUL, 1'b0, 1'b1, 32'hFFFFFFF4, ST_OK);
      add_row(8'hFF, 1'b0, 1'b0, 32'd0, ST_OK);
      add_row(8'h00, 1'b0, 1'b0, 32'd0, ST_OK);
      add_row(CH_ZERO + 8'd7, 1'b0, 1'b0, 32'd0, ST_OK);
      add_row(CH_DIV, 1'b0, 1'b0, 32'd0, ST_OK);
      add_row(8'h41, 1'b1, 1'b0, 32'd0, ST_OK);
      add_row(CH_ADD, 1'b0, 1'b1, 32'd0, ST_UNDERFLOW);
      for (int i = 0; i < STACK_DEPTH; i++)
         add_row(CH_NINE - 8'(i % 10), i == 0, 1'b0, 32'd0, ST_OK);
      add_row(CH_ZERO + 8'd5, 1'b0, 1'b1, 32'd0, ST_OVERFLOW);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stim_table[i]) begin
         send_item(stim_table[i].req);
         if (stim_table[i].check_typed) check_typed_row(stim_table[i]);
      end
      wait_drained();

      // Most negative value divided by minus one: minus one goes in first as
      // the right operand, then the most negative value is built on top.
      send_item(tok(CH_ZERO + 8'd1, 1'b1));
      send_item(tok(CH_ZERO, 1'b0));
      send_item(tok(CH_SUB, 1'b0));
      send_item(tok(CH_ZERO + 8'd1, 1'b0));
      send_item(tok(CH_ZERO, 1'b0));
      send_item(tok(CH_SUB, 1'b0));
      for (int i = 0; i < 31; i++) begin
         send_item(tok(CH_ZERO + 8'd2, 1'b0));
         send_item(tok(CH_MUL, 1'b0));
      end
      send_item(tok(CH_DIV, 1'b0));
      wait_drained();

      hold_off_cycles = 400;
      for (int i = 0; i < 12; i++) begin
         send_item(tok(CH_ZERO + 8'd4, 1'b1));
         send_item(tok(CH_ZERO + 8'd3, 1'b0));
         send_item(tok(CH_ADD, 1'b0));
      end
      wait_drained();

      sent = 0;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0; pop_stall_pct = 0; end
            1: begin send_idle_pct = 74; pop_stall_pct = 0; end
            2: begin send_idle_pct = 0; pop_stall_pct = 74; end
            default: begin send_idle_pct = 12; pop_stall_pct = 12; end
         endcase
         for (int k = 0; k < 15; k++) begin
            if ($urandom_range(9) == 0) begin
               repeat ($urandom_range(1, 8)) send_item(tok(8'($urandom), 1'($urandom)));
            end else begin
               send_random_expression();
            end
         end
      end
      send_idle_pct = 0;
      pop_stall_pct = 0;
      wait_drained();

      if (mismatch_count == 0) begin
         $display("tb_prefix_expression_stack_evaluator_core: PASS");
      end else begin
         $display("tb_prefix_expression_stack_evaluator_core: FAIL");
      end
      $finish;
   end
endmodule
